// File: hw/rtl/dcc_packet_bit_encoder_macros.svh
// Assertion macros for the DCC packet bit encoder RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef DCC_PACKET_BIT_ENCODER_MACROS_SVH
`define DCC_PACKET_BIT_ENCODER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define DCC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dcc encoder check failed");

// Next-cycle implication, disabled during reset
`define DCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dcc encoder check failed");

`endif

// File: hw/rtl/dcc_pkg.sv
// Types and constants for the DCC baseline packet bit encoder.
// Depends on nothing; imported by every module of the block.
package dcc_pkg;

  // Field widths
  localparam int ByteW     = 8;
  localparam int HalfW     = 10;
  localparam int PreW      = 5;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = HalfW;

  // Start bit, three bytes with two separators, end bit
  localparam int FrameBits = 28;
  localparam int FrameCntW = $clog2(FrameBits);
  localparam logic [FrameCntW-1:0] FrameLast = FrameCntW'(FrameBits - 1);

  // Preamble limits and register reset values
  localparam logic [PreW-1:0]  PreambleMin   = PreW'(10);
  localparam logic [PreW-1:0]  PreambleMax   = PreW'(30);
  localparam logic [PreW-1:0]  PreambleReset = PreW'(14);
  localparam logic [HalfW-1:0] OneResetUs    = HalfW'(58);
  localparam logic [HalfW-1:0] ZeroResetUs   = HalfW'(100);

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_ONE_HALF  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_ZERO_HALF = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_PREAMBLE  = CfgIdxW'(2);

  // Job queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [ByteW-1:0] address;
    logic [ByteW-1:0] instruction;
  } dcc_in_t;

  typedef struct packed {
    logic             bit_value;
    logic [HalfW-1:0] half_us;
    logic             last_bit;
  } dcc_out_t;

  // One classified packet waiting for serialization
  typedef struct packed {
    logic [FrameBits-1:0] frame;
    logic [PreW-1:0]      preamble;
  } dcc_job_t;

  // Bit timing handed to the serializer
  typedef struct packed {
    logic [HalfW-1:0] one_half_us;
    logic [HalfW-1:0] zero_half_us;
  } dcc_cfg_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PREAMBLE,
    PH_FRAME
  } phase_t;

endpackage

// File: hw/rtl/dcc_front.sv
// Front end: accepts packet requests, builds the bit frame and checksum.
// Depends on dcc_pkg.
module dcc_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  dcc_pkg::dcc_in_t   in_item,
  input  logic [4:0]         preamble_bits,
  input  logic               q_full,
  output logic               push,
  output dcc_pkg::dcc_job_t  job
);
  import dcc_pkg::*;

  logic [ByteW-1:0] check;
  logic [PreW-1:0]  pre_clamped;

  // Accept whenever the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // XOR checksum over address and instruction
  assign check = in_item.address ^ in_item.instruction;

  // Clamp preamble length to the legal range
  always_comb begin
    if (preamble_bits < PreambleMin) begin
      pre_clamped = PreambleMin;
    end else if (preamble_bits > PreambleMax) begin
      pre_clamped = PreambleMax;
    end else begin
      pre_clamped = preamble_bits;
    end
  end

  // Frame: start, address, sep, instruction, sep, checksum, end
  assign job.frame = {1'b0, in_item.address, 1'b0, in_item.instruction,
                      1'b0, check, 1'b1};
  assign job.preamble = pre_clamped;

endmodule

// File: hw/rtl/dcc_queue.sv
// Short job queue between the front end and the bit serializer.
// Depends on dcc_pkg.
module dcc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dcc_pkg::dcc_job_t  push_job,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output dcc_pkg::dcc_job_t  head
);
  import dcc_pkg::*;

  dcc_job_t           slots [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr;
  logic [QPtrW-1:0]   rd_ptr;
  logic [QCntW-1:0]   count;

  assign full    = (count == QCntW'(QueueDepth));
  assign q_valid = (count != '0);
  assign head    = slots[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/dcc_back.sv
// Back end: serializes queued jobs into one DCC bit per output beat.
// Depends on dcc_pkg and dcc_packet_bit_encoder_macros.svh.
module dcc_back (
  input  logic               clk,
  input  logic               rst,
  input  dcc_pkg::dcc_cfg_t  cfg,
  input  logic               q_valid,
  input  dcc_pkg::dcc_job_t  head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output dcc_pkg::dcc_out_t  out_item
);
  import dcc_pkg::*;
  `include "dcc_packet_bit_encoder_macros.svh"

  phase_t                state;
  phase_t                state_next;
  logic [PreW-1:0]       pre_cnt;
  logic [FrameCntW-1:0]  bit_cnt;
  logic [FrameBits-1:0]  frame;
  logic                  advance;
  logic                  emit;
  logic                  emit_bit;
  logic                  emit_last;
  logic [HalfW-1:0]      one_us;
  logic [HalfW-1:0]      zero_us;

  // Output register free or draining this cycle
  assign advance = !out_valid || out_ready;

  // Zero durations go out as one microsecond
  assign one_us  = (cfg.one_half_us == '0)  ? HalfW'(1) : cfg.one_half_us;
  assign zero_us = (cfg.zero_half_us == '0) ? HalfW'(1) : cfg.zero_half_us;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      PH_IDLE: begin
        if (advance && q_valid) begin
          state_next = PH_PREAMBLE;
        end
      end
      PH_PREAMBLE: begin
        if (advance && pre_cnt == PreW'(1)) begin
          state_next = PH_FRAME;
        end
      end
      PH_FRAME: begin
        if (advance && bit_cnt == FrameLast) begin
          state_next = PH_IDLE;
        end
      end
      default: state_next = PH_IDLE;
    endcase
  end

  // Beat contents; first preamble bit leaves as the job is taken
  always_comb begin
    emit      = 1'b0;
    emit_bit  = 1'b1;
    emit_last = 1'b0;
    pop       = 1'b0;
    case (state)
      PH_IDLE: begin
        pop  = advance && q_valid;
        emit = advance && q_valid;
      end
      PH_PREAMBLE: begin
        emit = advance;
      end
      PH_FRAME: begin
        emit      = advance;
        emit_bit  = frame[FrameBits-1];
        emit_last = (bit_cnt == FrameLast);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Control state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the output beat
  always_ff @(posedge clk) begin
    if (emit) begin
      out_item.bit_value <= emit_bit;
      out_item.half_us   <= emit_bit ? one_us : zero_us;
      out_item.last_bit  <= emit_last;
    end
  end

  // Take a job, count down the preamble, shift the frame
  always_ff @(posedge clk) begin
    if (pop) begin
      pre_cnt <= head.preamble - PreW'(1);
      frame   <= head.frame;
      bit_cnt <= '0;
    end else if (emit && state == PH_PREAMBLE) begin
      pre_cnt <= pre_cnt - PreW'(1);
    end else if (emit && state == PH_FRAME) begin
      frame   <= {frame[FrameBits-2:0], 1'b0};
      bit_cnt <= bit_cnt + 1'b1;
    end
  end

  `DCC_ASSERT_NOW(a_frame_after_preamble, clk, rst, state == PH_FRAME, pre_cnt == '0)
  `DCC_ASSERT_NOW(a_preamble_pending, clk, rst, state == PH_PREAMBLE, pre_cnt != '0)
  `DCC_ASSERT_NOW(a_end_bit_is_one, clk, rst, out_valid && out_item.last_bit, out_item.bit_value)
  `DCC_ASSERT_NEXT(a_idle_after_end, clk, rst, emit && emit_last, state == PH_IDLE)

endmodule

// File: hw/rtl/dcc_packet_bit_encoder.sv
// DCC baseline packet bit encoder: top level with configuration registers.
// Depends on dcc_pkg, dcc_front, dcc_queue and dcc_back.
//
// Input channel (in_valid/in_ready/in_item) takes one packet request per beat:
// an address byte and an instruction byte. Output channel (out_valid/out_ready/
// out_item) delivers the packet's DCC bits in order, one bit per beat, each
// with its half-cycle time in microseconds; the end bit carries last_bit.
// A packet is preamble (10..30 ones, clamped) plus 28 bits.
// A request is first written into the job queue; the serializer then takes it
// and registers its first bit into the output beat. With the receiver always
// ready, the serializer sends one bit per cycle and starts the next queued
// packet right after the end bit.
// A two-entry job queue lets requests be accepted while the serializer is
// busy; in_ready drops only when that queue is full.
// When the receiver stalls, the output beat holds and serialization pauses.
// Reset empties the queue, drops out_valid and loads the registers with
// one_half_us 58, zero_half_us 100 and preamble_bits 14.
// Write registers through cfg_we/cfg_addr/cfg_wdata only while idle.
module dcc_packet_bit_encoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dcc_pkg::dcc_in_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output dcc_pkg::dcc_out_t out_item,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [9:0]        cfg_wdata
);
  import dcc_pkg::*;

  logic [HalfW-1:0] one_half_us;
  logic [HalfW-1:0] zero_half_us;
  logic [PreW-1:0]  preamble_bits;
  dcc_cfg_t         timing;
  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             pop;
  dcc_job_t         job;
  dcc_job_t         head;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      one_half_us   <= OneResetUs;
      zero_half_us  <= ZeroResetUs;
      preamble_bits <= PreambleReset;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ONE_HALF:  one_half_us   <= cfg_wdata[HalfW-1:0];
        CFG_ZERO_HALF: zero_half_us  <= cfg_wdata[HalfW-1:0];
        CFG_PREAMBLE:  preamble_bits <= cfg_wdata[PreW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign timing.one_half_us  = one_half_us;
  assign timing.zero_half_us = zero_half_us;

  dcc_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .preamble_bits (preamble_bits),
    .q_full        (q_full),
    .push          (push),
    .job           (job)
  );

  dcc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  dcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (timing),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
